// ----- sv/nmea_sentence_checker_assert.svh -----
// Assertion macros for the NMEA sentence checker RTL.
// Included by any module that carries concurrent assertions; needs no package.
`ifndef NMEA_SENTENCE_CHECKER_ASSERT_SVH
`define NMEA_SENTENCE_CHECKER_ASSERT_SVH
`ifndef SYNTHESIS
`define NSC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("nsc assertion failed");
`define NSC_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("nsc assertion failed");
`else
`define NSC_ASSERT(lbl, clk, rst_n, prop)
`define NSC_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ----- sv/nsc_pkg.sv -----
// Shared types, codes and the hex digit decoder of the NMEA sentence checker.
// Used by nsc_cfg, nsc_track and nmea_sentence_checker; depends on nothing.
package nsc_pkg;

    localparam int unsigned BYTE_W = 8;

    typedef logic [BYTE_W-1:0] t_byte;

    typedef enum logic [1:0] {
        CFG_START  = 2'd0,
        CFG_MARKER = 2'd1,
        CFG_END    = 2'd2,
        CFG_NONE   = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_VALID     = 2'd0,
        ST_NO_MARKER = 2'd1,
        ST_MISMATCH  = 2'd2,
        ST_TOO_LONG  = 2'd3
    } t_status;

    typedef struct packed {
        t_byte start_char;
        t_byte marker_char;
        t_byte end_char;
    } t_cfg;

    typedef struct packed {
        t_byte   sentence_byte;
        logic    last;
        t_status status;
        t_byte   computed_sum;
        t_byte   received_sum;
    } t_result;

    // Returns {not_hex, nibble}; a non-hex byte decodes as zero.
    function automatic logic [4:0] hex_nibble(input t_byte c);
        t_byte d;
        logic [4:0] r;
        d = '0;
        r = {1'b1, 4'h0};
        if (c >= 8'd48 && c <= 8'd57) begin
            d = c - 8'd48;
            r = {1'b0, d[3:0]};
        end else if (c >= 8'd65 && c <= 8'd70) begin
            d = c - 8'd55;
            r = {1'b0, d[3:0]};
        end else if (c >= 8'd97 && c <= 8'd102) begin
            d = c - 8'd87;
            r = {1'b0, d[3:0]};
        end
        return r;
    endfunction

endpackage

// ----- sv/nmea_sentence_checker.sv -----
// NMEA sentence checker: takes one received byte per request and returns one request per
// sentence byte, start through end character, with the checksum status on the end byte.
// One byte per clock is sustained while i_stall is low; a taken byte is held in the input
// register, passes the framing and checksum logic and is presented from the result register.
// Bytes outside a sentence give no request.
// A stall on the output reaches o_stall in the same cycle only when both registers are full.
// Depends on nsc_pkg, nsc_cfg, nsc_track and nmea_sentence_checker_assert.svh.
module nmea_sentence_checker #(
    parameter int unsigned MAX_LEN = 128
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_rx_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_sentence_byte,
    output logic       o_last,
    output logic [1:0] o_status,
    output logic [7:0] o_computed_sum,
    output logic [7:0] o_received_sum
);
    import nsc_pkg::*;

    `include "nmea_sentence_checker_assert.svh"

    t_cfg    cfg;
    logic    r_in_valid;
    t_byte   r_in_byte;
    logic    r_out_valid;
    t_result r_out;
    logic    out_free;
    logic    in_free;
    logic    advance;
    logic    emit;
    t_result result;

    nsc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    nsc_track #(
        .MAX_LEN (MAX_LEN)
    ) u_track (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_byte    (r_in_byte),
        .i_advance (advance),
        .o_emit    (emit),
        .o_result  (result)
    );

    assign out_free = !r_out_valid || !i_stall;
    assign advance  = r_in_valid && out_free;
    assign in_free  = !r_in_valid || out_free;
    assign o_stall  = !in_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_free) begin
                r_in_valid <= i_valid;
            end
            if (out_free) begin
                r_out_valid <= advance && emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_free && i_valid) begin
            r_in_byte <= i_rx_byte;
        end
        if (advance && emit) begin
            r_out <= result;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_sentence_byte = r_out.sentence_byte;
    assign o_last          = r_out.last;
    assign o_status        = r_out.status;
    assign o_computed_sum  = r_out.computed_sum;
    assign o_received_sum  = r_out.received_sum;

    `NSC_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_valid && !o_stall)
    `NSC_ASSERT(a_plain_byte_zero, i_clk, i_rst_n,
        o_valid && !o_last |-> o_status == ST_VALID &&
        o_computed_sum == 8'd0 && o_received_sum == 8'd0)
    `NSC_ASSERT(a_no_marker_zero, i_clk, i_rst_n,
        o_valid && o_last && o_status == ST_NO_MARKER |-> o_received_sum == 8'd0)
    `NSC_ASSERT(a_held_result, i_clk, i_rst_n,
        o_valid && i_stall |=> o_valid && $stable(r_out))

endmodule

// ----- sv/nsc_cfg.sv -----
// Configuration registers of the NMEA sentence checker: start, marker and end bytes.
// Depends on nsc_pkg.
module nsc_cfg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_index,
    input  logic [7:0]       i_cfg_data,
    output nsc_pkg::t_cfg    o_cfg
);
    import nsc_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_START:  n_cfg.start_char  = i_cfg_data;
                CFG_MARKER: n_cfg.marker_char = i_cfg_data;
                CFG_END:    n_cfg.end_char    = i_cfg_data;
                default:    n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_char  <= 8'd36;
            r_cfg.marker_char <= 8'd42;
            r_cfg.end_char    <= 8'd10;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- sv/nsc_track.sv -----
// Sentence state and checksum logic: framing, running XOR, marker digits and status.
// Depends on nsc_pkg; driven by the input register of the top level.
module nsc_track #(
    parameter int unsigned MAX_LEN = 128
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  nsc_pkg::t_cfg     i_cfg,
    input  nsc_pkg::t_byte    i_byte,
    input  logic              i_advance,
    output logic              o_emit,
    output nsc_pkg::t_result  o_result
);
    import nsc_pkg::*;

    localparam t_byte LP_MAX = t_byte'(MAX_LEN);

    logic       r_in_sentence;
    t_byte      r_running_xor;
    t_byte      r_xor_at_marker;
    logic       r_marker_seen;
    logic [1:0] r_digits;
    t_byte      r_digit_value;
    logic       r_digits_bad;
    t_byte      r_byte_count;

    logic       n_in_sentence;
    t_byte      n_running_xor;
    t_byte      n_xor_at_marker;
    logic       n_marker_seen;
    logic [1:0] n_digits;
    t_byte      n_digit_value;
    logic       n_digits_bad;
    t_byte      n_byte_count;

    logic       is_start;
    logic       is_marker;
    logic       is_end;
    logic [4:0] nib;
    t_status    status;

    assign is_start  = !r_in_sentence && (i_byte == i_cfg.start_char);
    assign is_marker = (i_byte == i_cfg.marker_char);
    assign is_end    = (i_byte == i_cfg.end_char);
    assign nib       = hex_nibble(i_byte);
    assign o_emit    = r_in_sentence || is_start;

    always_comb begin
        n_in_sentence   = r_in_sentence;
        n_running_xor   = r_running_xor;
        n_xor_at_marker = r_xor_at_marker;
        n_marker_seen   = r_marker_seen;
        n_digits        = r_digits;
        n_digit_value   = r_digit_value;
        n_digits_bad    = r_digits_bad;
        n_byte_count    = r_byte_count;
        status          = ST_VALID;

        o_result.sentence_byte = i_byte;
        o_result.last          = 1'b0;
        o_result.status        = ST_VALID;
        o_result.computed_sum  = '0;
        o_result.received_sum  = '0;

        if (!r_in_sentence) begin
            if (is_start) begin
                n_in_sentence   = 1'b1;
                n_running_xor   = '0;
                n_xor_at_marker = '0;
                n_marker_seen   = 1'b0;
                n_digits        = '0;
                n_digit_value   = '0;
                n_digits_bad    = 1'b0;
                n_byte_count    = 8'd1;
            end
        end else begin
            if (is_marker) begin
                n_xor_at_marker = r_running_xor;
                n_marker_seen   = 1'b1;
                n_digits        = '0;
                n_digit_value   = '0;
                n_digits_bad    = 1'b0;
            end else if (r_marker_seen && !r_digits[1]) begin
                n_digits_bad  = r_digits_bad | nib[4];
                n_digit_value = {r_digit_value[3:0], nib[3:0]};
                n_digits      = r_digits + 2'd1;
            end

            if (is_end) begin
                if (r_byte_count >= LP_MAX) begin
                    status = ST_TOO_LONG;
                end else if (!n_marker_seen) begin
                    status = ST_NO_MARKER;
                end else if (!n_digits[1] || n_digits_bad ||
                             (n_digit_value != n_xor_at_marker)) begin
                    status = ST_MISMATCH;
                end else begin
                    status = ST_VALID;
                end
                o_result.last         = 1'b1;
                o_result.status       = status;
                o_result.computed_sum = n_marker_seen ? n_xor_at_marker : r_running_xor;
                o_result.received_sum = n_marker_seen ? n_digit_value : '0;
                n_in_sentence         = 1'b0;
            end else begin
                n_running_xor = r_running_xor ^ i_byte;
                if (r_byte_count != 8'd255) begin
                    n_byte_count = r_byte_count + 8'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_sentence   <= 1'b0;
            r_running_xor   <= '0;
            r_xor_at_marker <= '0;
            r_marker_seen   <= 1'b0;
            r_digits        <= '0;
            r_digit_value   <= '0;
            r_digits_bad    <= 1'b0;
            r_byte_count    <= '0;
        end else if (i_advance) begin
            r_in_sentence   <= n_in_sentence;
            r_running_xor   <= n_running_xor;
            r_xor_at_marker <= n_xor_at_marker;
            r_marker_seen   <= n_marker_seen;
            r_digits        <= n_digits;
            r_digit_value   <= n_digit_value;
            r_digits_bad    <= n_digits_bad;
            r_byte_count    <= n_byte_count;
        end
    end

endmodule

// ----- test/nmea_sentence_checker_test.sv -----
// Self-checking testbench for nmea_sentence_checker: byte streams in, sentence results out.
// A queue-fed driver, a clocked monitor and a built-in checksum tracker predict each result.
// Depends on nsc_pkg and the nmea_sentence_checker RTL.
`timescale 1ns / 1ps

module nmea_sentence_checker_test;

    import nsc_pkg::*;

    localparam int LEN_LIMIT = 128;
    localparam int LONG_HOLD = 90;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_we = 1'b0;
    logic [1:0] i_cfg_index = CFG_START;
    logic [7:0] i_cfg_data = '0;
    logic       i_valid = 1'b0;
    logic       o_stall;
    logic [7:0] i_rx_byte = '0;
    logic       o_valid;
    logic       i_stall = 1'b0;
    logic [7:0] o_sentence_byte;
    logic       o_last;
    logic [1:0] o_status;
    logic [7:0] o_computed_sum;
    logic [7:0] o_received_sum;

    nmea_sentence_checker #(
        .MAX_LEN(LEN_LIMIT)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_rx_byte(i_rx_byte),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_sentence_byte(o_sentence_byte),
        .o_last(o_last),
        .o_status(o_status),
        .o_computed_sum(o_computed_sum),
        .o_received_sum(o_received_sum)
    );

    always #6 i_clk = ~i_clk;

    logic [7:0] cfg_start = 8'd36;
    logic [7:0] cfg_marker = 8'd42;
    logic [7:0] cfg_end = 8'd10;

    logic       sentence_open = 1'b0;
    logic [7:0] run_xor = '0;
    logic [7:0] marker_xor = '0;
    logic       marker_hit = 1'b0;
    logic [1:0] digit_count = '0;
    logic [7:0] digit_acc = '0;
    logic       digit_fault = 1'b0;
    logic [7:0] length_count = '0;

    logic [7:0] rx_backlog[$];
    t_result    due_results[$];
    int         mismatch_count = 0;

    bit send_idle = 1'b0;
    bit recv_idle = 1'b0;
    int send_gap = 0;
    int recv_wait = 0;
    int hold_asked = 0;
    int hold_done = 0;
    bit rx_taken = 1'b0;
    bit out_taken = 1'b0;

    // Returns {is_hex, value}.
    function automatic logic [4:0] decode_hex(logic [7:0] c);
        logic [7:0] folded;
        folded = c | 8'h20;
        if (c >= 8'h30 && c <= 8'h39) return {1'b1, c[3:0]};
        if (folded >= 8'h61 && folded <= 8'h66) return {1'b1, c[3:0] + 4'd9};
        return 5'b0;
    endfunction

    function automatic void track_rx_byte(logic [7:0] b);
        t_result    r;
        logic [4:0] nib;
        r = '0;
        r.sentence_byte = b;
        if (!sentence_open) begin
            if (b != cfg_start) return;
            sentence_open = 1'b1;
            run_xor = '0;
            marker_xor = '0;
            marker_hit = 1'b0;
            digit_count = '0;
            digit_acc = '0;
            digit_fault = 1'b0;
            length_count = 8'd1;
            due_results.push_back(r);
            return;
        end
        if (b == cfg_marker) begin
            marker_xor = run_xor;
            marker_hit = 1'b1;
            digit_count = '0;
            digit_acc = '0;
            digit_fault = 1'b0;
        end else if (marker_hit && digit_count < 2) begin
            nib = decode_hex(b);
            if (!nib[4]) digit_fault = 1'b1;
            digit_acc = {digit_acc[3:0], nib[3:0]};
            digit_count = digit_count + 2'd1;
        end
        if (b == cfg_end) begin
            r.last = 1'b1;
            if (length_count >= LEN_LIMIT) begin
                r.status = ST_TOO_LONG;
            end else if (!marker_hit) begin
                r.status = ST_NO_MARKER;
            end else if (digit_count < 2 || digit_fault || digit_acc != marker_xor) begin
                r.status = ST_MISMATCH;
            end else begin
                r.status = ST_VALID;
            end
            r.computed_sum = marker_hit ? marker_xor : run_xor;
            r.received_sum = marker_hit ? digit_acc : 8'h00;
            sentence_open = 1'b0;
        end else begin
            run_xor = run_xor ^ b;
            if (length_count != 8'd255) length_count = length_count + 8'd1;
        end
        due_results.push_back(r);
    endfunction

    task automatic report_field(string label, logic [7:0] want, logic [7:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %h, got %h", $time, label, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_result want;
        rx_taken <= i_rst_n && i_valid && !o_stall;
        out_taken <= i_rst_n && o_valid === 1'b1 && !i_stall;
        if (i_rst_n && i_valid && !o_stall) track_rx_byte(i_rx_byte);
        if (i_rst_n && o_valid === 1'b1 && !i_stall) begin
            if (due_results.size() == 0) begin
                $display("%0t: unexpected request, expected none, got byte %h last %b",
                         $time, o_sentence_byte, o_last);
                mismatch_count++;
            end else begin
                want = due_results.pop_front();
                report_field("sentence_byte", want.sentence_byte, o_sentence_byte);
                report_field("last", 8'(want.last), 8'(o_last));
                report_field("status", 8'(want.status), 8'(o_status));
                report_field("computed_sum", want.computed_sum, o_computed_sum);
                report_field("received_sum", want.received_sum, o_received_sum);
            end
        end
    end

    always @(negedge i_clk) begin : driver
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || rx_taken) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                i_valid <= 1'b0;
            end else if (rx_backlog.size() > 0) begin
                i_rx_byte <= rx_backlog.pop_front();
                i_valid <= 1'b1;
                send_gap <= send_idle ? $urandom_range(0, 9) : 0;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin : receiver
        int w;
        w = recv_wait;
        if (hold_asked != hold_done) begin
            hold_done <= hold_asked;
            w = LONG_HOLD;
        end else if (out_taken && w == 0 && recv_idle) begin
            w = $urandom_range(0, 9);
        end
        if (w > 0) begin
            i_stall <= 1'b1;
            recv_wait <= w - 1;
        end else begin
            i_stall <= 1'b0;
            recv_wait <= 0;
        end
    end

    function automatic logic [7:0] hex_char(logic [3:0] n, bit lower);
        if (n < 4'd10) return 8'h30 + 8'(n);
        return (lower ? 8'h61 : 8'h41) + 8'(n) - 8'd10;
    endfunction

    function automatic logic [7:0] text_byte();
        logic [7:0] b;
        do b = 8'($urandom); while (b == cfg_marker || b == cfg_end);
        return b;
    endfunction

    task automatic push_text(string s);
        for (int i = 0; i < s.len(); i++) rx_backlog.push_back(s[i]);
    endtask

    task automatic add_sentence(int body_len);
        int         kind;
        logic [7:0] b;
        logic [7:0] sum;
        kind = $urandom_range(0, 99);
        if (body_len < 0) begin
            body_len = (kind < 2) ? $urandom_range(LEN_LIMIT - 8, LEN_LIMIT + 4)
                                  : $urandom_range(0, 12);
        end
        repeat ($urandom_range(0, 2)) rx_backlog.push_back(8'($urandom_range(0, 255)));
        rx_backlog.push_back(cfg_start);
        sum = '0;
        for (int i = 0; i < body_len; i++) begin
            if (kind >= 80 && kind < 88 && i == body_len / 2) b = cfg_marker;
            else b = text_byte();
            rx_backlog.push_back(b);
            sum = sum ^ b;
        end
        if (kind >= 94) begin
            rx_backlog.push_back(cfg_marker);
            repeat ($urandom_range(0, 2)) rx_backlog.push_back(8'($urandom_range(0, 255)));
        end else if (kind < 88) begin
            rx_backlog.push_back(cfg_marker);
            if ($urandom_range(0, 7) == 0) sum = sum ^ 8'(1 << $urandom_range(0, 7));
            rx_backlog.push_back(hex_char(sum[7:4], 1'($urandom_range(0, 1))));
            rx_backlog.push_back(hex_char(sum[3:0], 1'($urandom_range(0, 1))));
            if ($urandom_range(0, 5) == 0) begin
                repeat ($urandom_range(1, 3)) rx_backlog.push_back(text_byte());
            end
        end
        rx_backlog.push_back(cfg_end);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [7:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_START: cfg_start = val;
            CFG_MARKER: cfg_marker = val;
            CFG_END: cfg_end = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_chars(logic [7:0] s, logic [7:0] m, logic [7:0] e);
        write_reg(CFG_START, s);
        write_reg(CFG_MARKER, m);
        write_reg(CFG_END, e);
    endtask

    task automatic wait_drained();
        @(posedge i_clk);
        while (rx_backlog.size() != 0 || i_valid || due_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic run_phase(int n_items, bit snd, bit rcv, bit hold, int giant_len);
        send_idle = snd;
        recv_idle = rcv;
        @(posedge i_clk);
        if (giant_len > 0) add_sentence(giant_len);
        while (rx_backlog.size() < n_items) add_sentence(-1);
        if (hold) hold_asked++;
        wait_drained();
    endtask

    initial begin
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        set_chars(8'd36, 8'd42, 8'd10);
        @(posedge i_clk);
        rx_backlog.push_back(8'h00);
        rx_backlog.push_back(8'hFF);
        push_text("$A*41\n");
        push_text("$j*6a\n");
        rx_backlog.push_back(8'd36);
        rx_backlog.push_back(8'h00);
        rx_backlog.push_back(8'hFF);
        rx_backlog.push_back(8'd10);
        push_text("$*5\n");
        push_text("$$*G0\n");
        wait_drained();

        set_chars(8'd0, 8'd255, 8'd13);
        run_phase(250, 1'b1, 1'b1, 1'b0, 0);
        set_chars(8'd255, 8'd0, 8'd0);
        run_phase(150, 1'b0, 1'b1, 1'b0, 0);
        set_chars(8'($urandom), 8'($urandom), 8'($urandom));
        run_phase(250, 1'b1, 1'b0, 1'b1, 0);
        set_chars(8'd36, 8'd42, 8'd10);
        run_phase(300, 1'b1, 1'b1, 1'b1, 300);
        set_chars(8'($urandom), 8'($urandom), 8'($urandom));
        run_phase(250, 1'b0, 1'b0, 1'b0, 0);

        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
